// File: src/sptc_pkg.sv
// Shared types and constants of the sensor callback engine.
// No dependencies; every other file imports this package.
package sptc_pkg;

  // Operation codes on the input port
  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_TICK       = 2'd1,
    OP_SET_PERIOD = 2'd2,
    OP_SET_THRESH = 2'd3
  } op_t;

  // Result kinds on the output port
  typedef enum logic [1:0] {
    KIND_PERIOD  = 2'd0,
    KIND_THRESH  = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  // Stored threshold mode of a channel
  typedef enum logic [1:0] {
    MODE_OUTSIDE = 2'd0,
    MODE_INSIDE  = 2'd1,
    MODE_OFF     = 2'd2
  } mode_t;

  // Requested threshold mode codes; larger codes are invalid
  localparam logic [2:0] TM_OUTSIDE = 3'd0;
  localparam logic [2:0] TM_INSIDE  = 3'd1;
  localparam logic [2:0] TM_OFF     = 3'd2;
  localparam logic [2:0] TM_BELOW   = 3'd3;
  localparam logic [2:0] TM_ABOVE   = 3'd4;

  localparam logic [31:0] INT_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_NEG_MAX    = 32'h8000_0001;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [31:0] DEBOUNCE_RESET = 32'd100;

  // Results per tick are capped
  localparam int          MAX_RESULTS = 8;
  localparam int          CNT_W       = 4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic write_sample;
    logic set_period;
    logic set_thresh;
    logic clear_count;
    logic calc;
    logic period_step;
    logic thresh_step;
    logic flush;
  } cmd_t;

endpackage

// File: src/sensor_period_threshold_callbacks.sv
// Top level of the sensor callback engine: controller plus datapath.
// Depends on sptc_pkg, sptc_ctrl and sptc_dpath.
//
// Write-sample and setter beats never raise busy and may follow each other
// in every cycle; a setter's single result appears in the cycle after it
// is taken. A tick keeps busy high through a counter update state (if
// do_calculation) plus, with do_message, period checks over all channels,
// threshold checks over all channels and a closing state, as set by the
// channel walk of the controller, one channel per cycle and phase. Results
// come out as single-cycle strobes that cannot be held off; each callback
// of a tick is held until the next one is found or the closing state ends
// the walk, so the final one appears in the first cycle after busy falls,
// marked by last_of_run.
module sensor_period_threshold_callbacks #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               start,
  input  logic [1:0]         operation,
  input  logic [1:0]         channel,
  input  logic signed [31:0] sample_or_low,
  input  logic signed [31:0] threshold_upper,
  input  logic [31:0]        period_ticks,
  input  logic [2:0]         threshold_mode,
  input  logic               do_calculation,
  input  logic               do_message,
  output logic               busy,
  output logic               result_strobe,
  output logic [1:0]         result_kind,
  output logic [1:0]         result_channel,
  output logic signed [31:0] result_value,
  output logic               last_of_run
);
  import sptc_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cmd_t             cmd;
  logic [IDX_W-1:0] idx;

  sptc_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .operation      (operation),
    .do_calculation (do_calculation),
    .do_message     (do_message),
    .busy           (busy),
    .cmd            (cmd),
    .idx            (idx)
  );

  sptc_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .idx             (idx),
    .channel         (channel),
    .sample_or_low   (sample_or_low),
    .threshold_upper (threshold_upper),
    .period_ticks    (period_ticks),
    .threshold_mode  (threshold_mode),
    .result_strobe   (result_strobe),
    .result_kind     (result_kind),
    .result_channel  (result_channel),
    .result_value    (result_value),
    .last_of_run     (last_of_run)
  );

endmodule

// File: src/sptc_ctrl.sv
// Controller of the sensor callback engine: decodes accepted beats and
// sequences the tick phases over the channels. Depends on sptc_pkg.
module sptc_ctrl #(
  parameter int NUM_CHANNELS = 4,
  parameter int IDX_W        = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  logic               do_calculation,
  input  logic               do_message,
  output logic               busy,
  output sptc_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]   idx
);
  import sptc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CALC  = 5'b00010,
    ST_PER   = 5'b00100,
    ST_THR   = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx_next;
  logic             msg_pending, msg_pending_next;
  logic             accept;
  op_t              op;

  assign op     = op_t'(operation);
  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // Decode commands
  always_comb begin
    cmd              = '0;
    cmd.write_sample = accept && (op == OP_WRITE);
    cmd.set_period   = accept && (op == OP_SET_PERIOD);
    cmd.set_thresh   = accept && (op == OP_SET_THRESH);
    cmd.clear_count  = accept && (op == OP_TICK);
    cmd.calc         = (state == ST_CALC);
    cmd.period_step  = (state == ST_PER);
    cmd.thresh_step  = (state == ST_THR);
    cmd.flush        = (state == ST_FLUSH);
  end

  // Advance through the tick phases
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    msg_pending_next = msg_pending;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_TICK)) begin
          idx_next         = '0;
          msg_pending_next = do_message;
          if (do_calculation) state_next = ST_CALC;
          else if (do_message) state_next = ST_PER;
        end
      end
      ST_CALC: begin
        state_next = msg_pending ? ST_PER : ST_IDLE;
      end
      ST_PER: begin
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = ST_THR;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_THR: begin
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = ST_FLUSH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      msg_pending <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      msg_pending <= msg_pending_next;
    end
  end

endmodule

// File: src/sptc_dpath.sv
// Datapath of the sensor callback engine: per-channel state, threshold
// tests, result hold stage and output registers. Depends on sptc_pkg.
module sptc_dpath #(
  parameter int NUM_CHANNELS = 4,
  parameter int IDX_W        = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  sptc_pkg::cmd_t     cmd,
  input  logic [IDX_W-1:0]   idx,
  input  logic [1:0]         channel,
  input  logic signed [31:0] sample_or_low,
  input  logic signed [31:0] threshold_upper,
  input  logic [31:0]        period_ticks,
  input  logic [2:0]         threshold_mode,
  output logic               result_strobe,
  output logic [1:0]         result_kind,
  output logic [1:0]         result_channel,
  output logic signed [31:0] result_value,
  output logic               last_of_run
);
  import sptc_pkg::*;

  logic [31:0] debounce_ticks;
  logic [31:0] sample_store   [NUM_CHANNELS];
  logic [31:0] last_reported  [NUM_CHANNELS];
  logic [31:0] period_setting [NUM_CHANNELS];
  logic [31:0] period_count   [NUM_CHANNELS];
  logic [31:0] debounce_count [NUM_CHANNELS];
  mode_t       active_mode    [NUM_CHANNELS];
  logic [31:0] bound_low      [NUM_CHANNELS];
  logic [31:0] bound_high     [NUM_CHANNELS];

  logic             valid_ch;
  logic [IDX_W-1:0] ch_idx;
  logic             mode_ok;
  logic             set_bad;
  mode_t            new_mode;
  logic [31:0]      new_low, new_high;

  logic [31:0]      cur_sample;
  logic             per_hit, thr_hit, room, emit;
  logic [CNT_W-1:0] count;

  logic             pend_valid;
  kind_t            pend_kind;
  logic [1:0]       pend_ch;
  logic [31:0]      pend_value;

  kind_t            out_kind;
  logic [1:0]       out_ch;
  logic [31:0]      out_value;

  assign valid_ch = (32'(channel) < 32'(NUM_CHANNELS));
  assign ch_idx   = IDX_W'(channel);
  assign mode_ok  = (threshold_mode <= TM_ABOVE);
  assign set_bad  = !valid_ch || (cmd.set_thresh && !mode_ok);

  // Map the requested threshold mode to a stored mode and bounds
  always_comb begin
    new_mode = MODE_OUTSIDE;
    new_low  = sample_or_low;
    new_high = threshold_upper;
    priority if (threshold_mode == TM_INSIDE) begin
      new_mode = MODE_INSIDE;
    end else if (threshold_mode == TM_OFF) begin
      new_mode = MODE_OFF;
    end else if (threshold_mode == TM_BELOW) begin
      new_high = INT_MAX;
    end else if (threshold_mode == TM_ABOVE) begin
      new_low  = INT_NEG_MAX;
      new_high = sample_or_low;
    end else begin
      new_mode = MODE_OUTSIDE;
    end
  end

  // Test the walked channel
  assign cur_sample = sample_store[idx];
  assign per_hit = (period_setting[idx] != '0) &&
                   (period_setting[idx] <= period_count[idx]) &&
                   (last_reported[idx] != cur_sample);
  always_comb begin
    thr_hit = 1'b0;
    if (active_mode[idx] == MODE_OUTSIDE) begin
      thr_hit = ($signed(cur_sample) < $signed(bound_low[idx])) ||
                ($signed(cur_sample) > $signed(bound_high[idx]));
    end else if (active_mode[idx] == MODE_INSIDE) begin
      thr_hit = ($signed(cur_sample) > $signed(bound_low[idx])) &&
                ($signed(cur_sample) < $signed(bound_high[idx]));
    end
    thr_hit = thr_hit && (debounce_count[idx] == debounce_ticks);
  end
  assign room = (count < CNT_W'(MAX_RESULTS));
  assign emit = room && ((cmd.period_step && per_hit) || (cmd.thresh_step && thr_hit));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_ticks <= cfg_wr_data;
    end
  end

  // Per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sample_store[i]   <= '0;
        last_reported[i]  <= ALL_ONES;
        period_setting[i] <= '0;
        period_count[i]   <= '0;
        debounce_count[i] <= '0;
        active_mode[i]    <= MODE_OFF;
        bound_low[i]      <= '0;
        bound_high[i]     <= '0;
      end
    end else begin
      if (cmd.write_sample && valid_ch) begin
        sample_store[ch_idx] <= sample_or_low;
      end
      if (cmd.set_period && valid_ch) begin
        period_setting[ch_idx] <= period_ticks;
      end
      if (cmd.set_thresh && !set_bad) begin
        active_mode[ch_idx]    <= new_mode;
        bound_low[ch_idx]      <= new_low;
        bound_high[ch_idx]     <= new_high;
        debounce_count[ch_idx] <= debounce_ticks;
      end
      // Advance all counters at once
      if (cmd.calc) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (period_count[i] != ALL_ONES) period_count[i] <= period_count[i] + 32'd1;
          if (debounce_count[i] != debounce_ticks) begin
            debounce_count[i] <= debounce_count[i] + 32'd1;
          end
        end
      end
      if (emit && cmd.period_step) begin
        period_count[idx]  <= '0;
        last_reported[idx] <= cur_sample;
      end
      if (emit && cmd.thresh_step) begin
        debounce_count[idx] <= '0;
      end
    end
  end

  // Hold the newest callback so the last one of a run can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      count         <= '0;
      result_strobe <= 1'b0;
      last_of_run   <= 1'b0;
    end else begin
      result_strobe <= cmd.set_period || cmd.set_thresh ||
                       ((emit || cmd.flush) && pend_valid);
      last_of_run   <= cmd.set_period || cmd.set_thresh || (cmd.flush && pend_valid);
      pend_valid    <= emit || (pend_valid && !cmd.flush);
      if (cmd.clear_count) count <= '0;
      else if (emit) count <= count + 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.set_period || cmd.set_thresh) begin
      out_kind  <= set_bad ? KIND_INVALID : KIND_ACK;
      out_ch    <= channel;
      out_value <= '0;
    end else if (emit || cmd.flush) begin
      out_kind  <= pend_kind;
      out_ch    <= pend_ch;
      out_value <= pend_value;
    end
    if (emit) begin
      pend_kind  <= cmd.period_step ? KIND_PERIOD : KIND_THRESH;
      pend_ch    <= 2'(idx);
      pend_value <= cur_sample;
    end
  end

  assign result_kind    = out_kind;
  assign result_channel = out_ch;
  assign result_value   = out_value;

endmodule

// File: src/sptc_checker.sv
// Port-level checks of the sensor callback engine, bound to the top level.
// Depends on sptc_pkg.
module sptc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic [1:0] operation,
  input logic       do_calculation,
  input logic       do_message,
  input logic       busy,
  input logic       result_strobe,
  input logic [1:0] result_kind,
  input logic       last_of_run
);
  import sptc_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // A setter beat answers with exactly one final result in the next cycle
  a_setter_answers: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_SET_PERIOD || operation == OP_SET_THRESH)
    |=> result_strobe && last_of_run &&
        (result_kind == KIND_ACK || result_kind == KIND_INVALID))
    else $error("setter beat did not give one final ack or invalid result");

  // A sample write gives no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_WRITE) |=> !result_strobe)
    else $error("sample write produced a result");

  // A tick with any phase holds off further beats
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_TICK) && (do_calculation || do_message) |=> busy)
    else $error("tick did not raise busy");

  // A tick without message phase emits nothing
  a_calc_only_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_TICK) && !do_message
    |=> !result_strobe)
    else $error("calculation-only tick produced a result");

endmodule

bind sensor_period_threshold_callbacks sptc_checker u_sptc_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .operation      (operation),
  .do_calculation (do_calculation),
  .do_message     (do_message),
  .busy           (busy),
  .result_strobe  (result_strobe),
  .result_kind    (result_kind),
  .last_of_run    (last_of_run)
);

// File: verif/sptc_callback_monitor.sv
// Callback monitor for the sensor callback engine: predicts every result beat
// from the accepted commands and register writes, and compares it on arrival.
// Depends on sptc_pkg; instantiated next to the engine by the testbench top.
module sptc_callback_monitor #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         operation,
  input  logic [1:0]         channel,
  input  logic signed [31:0] sample_or_low,
  input  logic signed [31:0] threshold_upper,
  input  logic [31:0]        period_ticks,
  input  logic [2:0]         threshold_mode,
  input  logic               do_calculation,
  input  logic               do_message,
  input  logic               result_strobe,
  input  logic [1:0]         result_kind,
  input  logic [1:0]         result_channel,
  input  logic signed [31:0] result_value,
  input  logic               last_of_run,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sptc_pkg::*;

  typedef struct {
    kind_t              kind;
    logic [1:0]         chan;
    logic signed [31:0] value;
    logic               last;
  } result_beat_t;

  // Per-channel mirror of the engine state
  logic [31:0]        debounce_limit;
  logic signed [31:0] sample_mem   [NUM_CHANNELS];
  logic [31:0]        reported_mem [NUM_CHANNELS];
  logic [31:0]        period_len   [NUM_CHANNELS];
  logic [31:0]        period_cnt   [NUM_CHANNELS];
  logic [31:0]        debounce_cnt [NUM_CHANNELS];
  mode_t              mode_mem     [NUM_CHANNELS];
  logic signed [31:0] low_mem      [NUM_CHANNELS];
  logic signed [31:0] high_mem     [NUM_CHANNELS];

  result_beat_t expected_beats[$];
  int           mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %08h, want %08h", $realtime, what, got, want);
  endtask

  function automatic void clear_state();
    debounce_limit = DEBOUNCE_RESET;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sample_mem[i]   = '0;
      reported_mem[i] = ALL_ONES;
      period_len[i]   = '0;
      period_cnt[i]   = '0;
      debounce_cnt[i] = '0;
      mode_mem[i]     = MODE_OFF;
      low_mem[i]      = '0;
      high_mem[i]     = '0;
    end
    expected_beats.delete();
  endfunction

  // Work out the result beats of one accepted command and queue them
  function automatic void predict_command(op_t op, logic [1:0] ch, logic signed [31:0] lo,
                                          logic signed [31:0] hi, logic [31:0] per,
                                          logic [2:0] tmode, logic calc, logic msg);
    result_beat_t run[$];
    result_beat_t beat;
    logic         ch_ok;
    logic         hit;
    ch_ok = int'(ch) < NUM_CHANNELS;
    case (op)
      OP_WRITE: begin
        if (ch_ok) sample_mem[ch] = lo;
      end
      OP_SET_PERIOD: begin
        if (ch_ok) begin
          period_len[ch] = per;
          run.push_back('{KIND_ACK, ch, 32'sd0, 1'b0});
        end else begin
          run.push_back('{KIND_INVALID, ch, 32'sd0, 1'b0});
        end
      end
      OP_SET_THRESH: begin
        if (!ch_ok || tmode > TM_ABOVE) begin
          run.push_back('{KIND_INVALID, ch, 32'sd0, 1'b0});
        end else begin
          // Map below and above onto outside with one open bound
          case (tmode)
            TM_BELOW: begin
              mode_mem[ch] = MODE_OUTSIDE;
              low_mem[ch]  = lo;
              high_mem[ch] = INT_MAX;
            end
            TM_ABOVE: begin
              mode_mem[ch] = MODE_OUTSIDE;
              low_mem[ch]  = INT_NEG_MAX;
              high_mem[ch] = lo;
            end
            default: begin
              mode_mem[ch] = mode_t'(tmode[1:0]);
              low_mem[ch]  = lo;
              high_mem[ch] = hi;
            end
          endcase
          debounce_cnt[ch] = debounce_limit;
          run.push_back('{KIND_ACK, ch, 32'sd0, 1'b0});
        end
      end
      default: begin
        // Counter update: period saturates, debounce stops at the limit
        if (calc) begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (period_cnt[i] != ALL_ONES) period_cnt[i]++;
            if (debounce_cnt[i] != debounce_limit) debounce_cnt[i]++;
          end
        end
        if (msg) begin
          // Period callbacks for changed samples whose period has elapsed
          for (int i = 0; i < NUM_CHANNELS && run.size() < MAX_RESULTS; i++) begin
            if (period_len[i] != 0 && period_len[i] <= period_cnt[i] &&
                reported_mem[i] != sample_mem[i]) begin
              run.push_back('{KIND_PERIOD, 2'(i), sample_mem[i], 1'b0});
              period_cnt[i]   = '0;
              reported_mem[i] = sample_mem[i];
            end
          end
          // Debounced threshold callbacks, signed compare
          for (int i = 0; i < NUM_CHANNELS && run.size() < MAX_RESULTS; i++) begin
            hit = (mode_mem[i] == MODE_OUTSIDE &&
                   (sample_mem[i] < low_mem[i] || sample_mem[i] > high_mem[i])) ||
                  (mode_mem[i] == MODE_INSIDE &&
                   sample_mem[i] > low_mem[i] && sample_mem[i] < high_mem[i]);
            if (hit && debounce_cnt[i] == debounce_limit) begin
              run.push_back('{KIND_THRESH, 2'(i), sample_mem[i], 1'b0});
              debounce_cnt[i] = '0;
            end
          end
        end
      end
    endcase
    // Flag the final beat of the run and queue the lot
    for (int k = 0; k < run.size(); k++) begin
      beat      = run[k];
      beat.last = (k == run.size() - 1);
      expected_beats.push_back(beat);
    end
  endfunction

  // Compare one result beat with the oldest expectation
  task automatic check_result();
    result_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("result with none expected", result_value, '0);
    end else begin
      want = expected_beats.pop_front();
      if (result_kind !== want.kind)
        report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
      if (result_channel !== want.chan)
        report_mismatch("result_channel", 32'(result_channel), 32'(want.chan));
      if (result_value !== want.value)
        report_mismatch("result_value", result_value, want.value);
      if (last_of_run !== want.last)
        report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
    end
  endtask

  // Sample at the rising edge: results, register writes, then commands
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if ($isunknown(result_strobe)) report_mismatch("result_strobe unknown", '0, '0);
      if ($isunknown(busy)) report_mismatch("busy unknown", '0, '0);
      if (result_strobe === 1'b1) check_result();
      if (cfg_wr_en) debounce_limit = cfg_wr_data;
      if (start && busy === 1'b0)
        predict_command(op_t'(operation), channel, sample_or_low, threshold_upper,
                        period_ticks, threshold_mode, do_calculation, do_message);
    end
    fail_count <= mismatches;
    pending    <= expected_beats.size();
  end

endmodule

// File: verif/sensor_period_threshold_callbacks_tb.sv
// Testbench top of the sensor callback engine: clock, reset, command stimulus
// and the verdict. Depends on sptc_pkg, the engine and sptc_callback_monitor.
module sensor_period_threshold_callbacks_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sptc_pkg::*;

  localparam int          NUM_CHANNELS   = 4;
  localparam int          PHASES         = 6;
  localparam int          PHASE_ITEMS    = 52;
  localparam int          SETTLE_CYCLES  = 2 * NUM_CHANNELS + 8;
  localparam int          WATCHDOG_LIMIT = 500;
  localparam logic [31:0] INT_MIN_BITS   = 32'h8000_0000;
  localparam logic [2:0]  TM_FIRST_BAD   = TM_ABOVE + 3'd1;
  localparam logic [2:0]  TM_LAST_CODE   = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [31:0]        cfg_wr_data;
  logic               start;
  logic [1:0]         operation;
  logic [1:0]         channel;
  logic signed [31:0] sample_or_low;
  logic signed [31:0] threshold_upper;
  logic [31:0]        period_ticks;
  logic [2:0]         threshold_mode;
  logic               do_calculation;
  logic               do_message;
  logic               busy;
  logic               result_strobe;
  logic [1:0]         result_kind;
  logic [1:0]         result_channel;
  logic signed [31:0] result_value;
  logic               last_of_run;
  int                 fail_count;
  int                 pending;

  int                 gap_pct;
  int                 quiet_cycles;
  logic [31:0]        debounce_plan [PHASES];
  int                 phase_gap_pct [PHASES];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sensor_period_threshold_callbacks #(.NUM_CHANNELS(NUM_CHANNELS)) uut (.*);

  sptc_callback_monitor #(.NUM_CHANNELS(NUM_CHANNELS)) callback_mon (.*);

  // Count cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Present one command beat, after an optional idle burst, and hold it until taken
  task automatic issue_beat(op_t op, logic [1:0] ch, logic [31:0] lo, logic [31:0] hi,
                            logic [31:0] per, logic [2:0] tmode, logic calc, logic msg);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start           <= 1'b1;
    operation       <= op;
    channel         <= ch;
    sample_or_low   <= lo;
    threshold_upper <= hi;
    period_ticks    <= per;
    threshold_mode  <= tmode;
    do_calculation  <= calc;
    do_message      <= msg;
    do @(posedge clk); while (busy);
  endtask

  // Drop start, wait for every expected result, then let the engine go quiet
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_debounce(logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly small values near the bounds, sometimes any 32-bit pattern
  function automatic logic [31:0] pick_level();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 16) - 8;
  endfunction

  task automatic random_command();
    int          pick;
    op_t         op;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] per;
    logic [2:0]  tmode;
    logic        calc;
    logic        msg;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_WRITE;
    else if (pick < 75) op = OP_TICK;
    else if (pick < 88) op = OP_SET_THRESH;
    else op = OP_SET_PERIOD;
    lo = pick_level();
    if ($urandom_range(0, 9) < 7) hi = lo + $urandom_range(1, 8);
    else hi = pick_level();
    if ($urandom_range(0, 4) == 0) per = $urandom();
    else per = $urandom_range(0, 4);
    if ($urandom_range(0, 99) < 85) tmode = 3'($urandom_range(TM_OUTSIDE, TM_ABOVE));
    else tmode = 3'($urandom_range(TM_FIRST_BAD, TM_LAST_CODE));
    if ($urandom_range(0, 3) != 0) begin
      calc = 1'b1;
      msg  = 1'b1;
    end else begin
      calc = 1'($urandom_range(0, 1));
      msg  = 1'($urandom_range(0, 1));
    end
    issue_beat(op, 2'($urandom_range(0, 3)), lo, hi, per, tmode, calc, msg);
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    start           <= 1'b0;
    operation       <= OP_WRITE;
    channel         <= '0;
    sample_or_low   <= '0;
    threshold_upper <= '0;
    period_ticks    <= '0;
    threshold_mode  <= TM_OFF;
    do_calculation  <= 1'b0;
    do_message      <= 1'b0;
    gap_pct = 25;
    debounce_plan = '{32'd0, 32'd1, ALL_ONES, 32'd3, 32'd2, 32'd0};
    debounce_plan[PHASES - 1] = $urandom_range(0, 6);
    phase_gap_pct = '{30, 0, 50, 20, 40, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick, period extremes, sample extremes, every threshold mode
    issue_beat(OP_TICK, 2'd0, '0, '0, '0, TM_OFF, 1'b1, 1'b1);
    issue_beat(OP_SET_PERIOD, 2'd0, '0, '0, 32'd1, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_SET_PERIOD, 2'd1, '0, '0, ALL_ONES, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_SET_PERIOD, 2'd3, '0, '0, 32'd2, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_WRITE, 2'd0, INT_MAX, '0, '0, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_WRITE, 2'd1, INT_MIN_BITS, '0, '0, TM_OFF, 1'b0, 1'b0);
    // Sample equal to the reset value of the last report
    issue_beat(OP_WRITE, 2'd2, ALL_ONES, '0, '0, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_WRITE, 2'd3, '0, ALL_ONES, ALL_ONES, TM_LAST_CODE, 1'b1, 1'b1);
    issue_beat(OP_SET_THRESH, 2'd0, -32'sd5, 32'sd5, '0, TM_OUTSIDE, 1'b0, 1'b0);
    issue_beat(OP_SET_THRESH, 2'd1, INT_MIN_BITS, INT_MAX, '0, TM_INSIDE, 1'b0, 1'b0);
    issue_beat(OP_SET_THRESH, 2'd2, '0, ALL_ONES, '0, TM_BELOW, 1'b0, 1'b0);
    issue_beat(OP_SET_THRESH, 2'd3, -32'sd10, '0, '0, TM_ABOVE, 1'b0, 1'b0);
    issue_beat(OP_SET_THRESH, 2'd1, '0, '0, '0, TM_FIRST_BAD, 1'b0, 1'b0);
    issue_beat(OP_SET_THRESH, 2'd2, '0, '0, '0, TM_LAST_CODE, 1'b0, 1'b0);
    // Tick phase combinations
    issue_beat(OP_TICK, 2'd0, '0, '0, '0, TM_OFF, 1'b0, 1'b1);
    issue_beat(OP_TICK, 2'd0, '0, '0, '0, TM_OFF, 1'b1, 1'b1);
    issue_beat(OP_TICK, 2'd0, '0, '0, '0, TM_OFF, 1'b1, 1'b0);
    issue_beat(OP_TICK, 2'd0, '0, '0, '0, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_TICK, 2'd0, '0, '0, '0, TM_OFF, 1'b1, 1'b1);
    issue_beat(OP_SET_THRESH, 2'd0, INT_MAX, INT_MIN_BITS, '0, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_SET_THRESH, 2'd3, INT_MIN_BITS, INT_MIN_BITS, '0, TM_OUTSIDE, 1'b0, 1'b0);
    issue_beat(OP_SET_PERIOD, 2'd2, '0, '0, INT_MIN_BITS, TM_OFF, 1'b0, 1'b0);
    issue_beat(OP_TICK, 2'd0, '0, '0, '0, TM_OFF, 1'b1, 1'b1);

    // Random phases, each under its own debounce setting
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      program_debounce(debounce_plan[p]);
      gap_pct = phase_gap_pct[p];
      for (int k = 0; k < PHASE_ITEMS; k++) random_command();
    end

    settle_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
